FILE: src/spi_flash_request_planner_defines.svh
// Assertion macros used by the checker file.
`ifndef SPI_FLASH_REQUEST_PLANNER_DEFINES_SVH
`define SPI_FLASH_REQUEST_PLANNER_DEFINES_SVH

// Clocked on aclk, off while aresetn is low.
`define SFRP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Clocked on aclk, also checked during reset.
`define SFRP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: src/sfrp_pkg.sv
package sfrp_pkg;

    localparam int ADDR_W   = 24;
    localparam int COUNT_W  = 14;
    localparam int OP_W     = 8;
    localparam int END_W    = 25;
    localparam int CMD_W    = 2;
    localparam int DIR_W    = 2;
    localparam int CFG_IDX_W = 3;

    localparam int PAGE_BYTES         = 256;
    localparam int MAX_REQUEST_BYTES  = 8192;
    localparam int PARAM_SECTOR_BYTES = 4096;
    localparam int SECTOR_BYTES       = 65536;
    localparam int PAGE_W             = $clog2(PAGE_BYTES);

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 56;

    // m_tdata field positions
    localparam int OP_LSB    = 0;
    localparam int ADDR_LSB  = 8;
    localparam int HAS_LSB   = 32;
    localparam int COUNT_LSB = 33;
    localparam int DIR_LSB   = 47;
    localparam int WREN_LSB  = 49;
    localparam int POLL_LSB  = 50;

    localparam logic [CMD_W-1:0] CMD_READ        = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE       = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SECTOR_ERASE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CHIP_ERASE  = 2'd3;

    localparam logic [DIR_W-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_W-1:0] DIR_TX   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RX   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_READ_OP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROGRAM_OP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_OP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PARAM_OP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CHIP_OP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PARAM_END  = 3'd5;

    localparam logic [OP_W-1:0]  RST_READ_OP    = 8'h03;
    localparam logic [OP_W-1:0]  RST_PROGRAM_OP = 8'h02;
    localparam logic [OP_W-1:0]  RST_SECTOR_OP  = 8'hD8;
    localparam logic [OP_W-1:0]  RST_PARAM_OP   = 8'h20;
    localparam logic [OP_W-1:0]  RST_CHIP_OP    = 8'h60;
    localparam logic [END_W-1:0] RST_PARAM_END  = 25'd65536;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]    opcode;
        logic [ADDR_W-1:0]  flash_address;
        logic               has_address;
        logic [COUNT_W-1:0] byte_count;
        logic [DIR_W-1:0]   direction;
        logic               enable_first;
        logic               poll_after;
        logic               last;
    } desc_t;

endpackage

FILE: src/spi_flash_request_planner.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: address, length; s_tuser: command
// m_        out  m_tvalid/m_tready  m_tdata: descriptor fields; m_tlast: last
// cfg_      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One request is taken in the idle state; the block is not ready again until
// its last descriptor has gone out. Each descriptor is worked out in the
// chunk unit (min/subtract/advance) in the calc state and then held on m_ in
// the send state; a read or erase gives one descriptor, a write one per page chunk.
// m_tready low holds the current descriptor. Reset is synchronous and loads
// the register defaults; s_tready and cfg_ready stay low while in reset.
module spi_flash_request_planner (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [23:0] address, [37:24] length, [39:38] zero
    input  logic [sfrp_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] command
    input  logic [sfrp_pkg::CMD_W-1:0]       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] opcode, [31:8] flash_address, [32] has_address, [46:33] byte_count,
    // [48:47] direction, [49] enable_first, [50] poll_after, [55:51] zero
    output logic [sfrp_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sfrp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfrp_pkg::END_W-1:0]       cfg_data
);

    localparam int ROOM_W = sfrp_pkg::PAGE_W + 1;

    sfrp_pkg::state_t state_reg, state_next;

    logic [sfrp_pkg::CMD_W-1:0]   cmd_reg;
    logic [sfrp_pkg::ADDR_W-1:0]  addr_reg;
    logic [sfrp_pkg::COUNT_W-1:0] left_reg;

    logic [sfrp_pkg::OP_W-1:0]  read_op_reg, program_op_reg, sector_op_reg;
    logic [sfrp_pkg::OP_W-1:0]  param_op_reg, chip_op_reg;
    logic [sfrp_pkg::END_W-1:0] param_end_reg;

    logic [sfrp_pkg::M_TDATA_W-1:0] tdata_reg;
    logic                           tlast_reg;

    logic s_accept, cfg_accept, load_req, load_desc, drop_req;

    logic [sfrp_pkg::COUNT_W-1:0] len_in, len_clamped;
    logic [ROOM_W-1:0]            room;
    logic [sfrp_pkg::COUNT_W-1:0] room_ext, chunk, left_after;
    logic [sfrp_pkg::ADDR_W-1:0]  addr_adv, param_aligned, sector_aligned;
    logic                         below_param;
    sfrp_pkg::desc_t              desc;

    localparam logic [sfrp_pkg::ADDR_W-1:0] PARAM_MASK =
        sfrp_pkg::ADDR_W'(sfrp_pkg::PARAM_SECTOR_BYTES - 1);
    localparam logic [sfrp_pkg::ADDR_W-1:0] SECTOR_MASK =
        sfrp_pkg::ADDR_W'(sfrp_pkg::SECTOR_BYTES - 1);
    localparam logic [sfrp_pkg::COUNT_W-1:0] MAX_LEN =
        sfrp_pkg::COUNT_W'(sfrp_pkg::MAX_REQUEST_BYTES);

    assign s_accept   = s_tvalid && s_tready;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign cfg_ready  = aresetn;

    assign len_in      = s_tdata[37:24];
    assign len_clamped = (len_in > MAX_LEN) ? MAX_LEN : len_in;

    // chunk unit: bytes left in the current page, capped by what is left
    assign room       = ROOM_W'(sfrp_pkg::PAGE_BYTES) -
                        {1'b0, addr_reg[sfrp_pkg::PAGE_W-1:0]};
    assign room_ext   = sfrp_pkg::COUNT_W'(room);
    assign chunk      = (left_reg < room_ext) ? left_reg : room_ext;
    assign left_after = left_reg - chunk;
    assign addr_adv   = addr_reg + sfrp_pkg::ADDR_W'(chunk);

    assign below_param    = {1'b0, addr_reg} < param_end_reg;
    assign param_aligned  = addr_reg & ~PARAM_MASK;
    assign sector_aligned = addr_reg & ~SECTOR_MASK;

    always_comb begin
        desc = '0;
        case (cmd_reg)
            sfrp_pkg::CMD_READ: begin
                desc.opcode        = read_op_reg;
                desc.flash_address = addr_reg;
                desc.has_address   = 1'b1;
                desc.byte_count    = left_reg;
                desc.direction     = sfrp_pkg::DIR_RX;
                desc.last          = 1'b1;
            end
            sfrp_pkg::CMD_WRITE: begin
                desc.opcode        = program_op_reg;
                desc.flash_address = addr_reg;
                desc.has_address   = 1'b1;
                desc.byte_count    = chunk;
                desc.direction     = sfrp_pkg::DIR_TX;
                desc.enable_first  = 1'b1;
                desc.poll_after    = 1'b1;
                desc.last          = (left_after == '0);
            end
            sfrp_pkg::CMD_SECTOR_ERASE: begin
                desc.opcode        = below_param ? param_op_reg : sector_op_reg;
                desc.flash_address = below_param ? param_aligned : sector_aligned;
                desc.has_address   = 1'b1;
                desc.direction     = sfrp_pkg::DIR_NONE;
                desc.enable_first  = 1'b1;
                desc.last          = 1'b1;
            end
            default: begin
                desc.opcode        = chip_op_reg;
                desc.direction     = sfrp_pkg::DIR_NONE;
                desc.enable_first  = 1'b1;
                desc.last          = 1'b1;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sfrp_pkg::ST_IDLE: begin
                if (s_accept) state_next = sfrp_pkg::ST_CALC;
            end
            sfrp_pkg::ST_CALC: begin
                state_next = drop_req ? sfrp_pkg::ST_IDLE : sfrp_pkg::ST_SEND;
            end
            sfrp_pkg::ST_SEND: begin
                if (m_tready) begin
                    state_next = tlast_reg ? sfrp_pkg::ST_IDLE : sfrp_pkg::ST_CALC;
                end
            end
            default: state_next = sfrp_pkg::ST_IDLE;
        endcase
    end

    // outputs and load strobes
    always_comb begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        load_req  = 1'b0;
        load_desc = 1'b0;
        // a write with nothing left emits nothing
        drop_req  = (cmd_reg == sfrp_pkg::CMD_WRITE) && (left_reg == '0);
        case (state_reg)
            sfrp_pkg::ST_IDLE: begin
                s_tready = aresetn;
                load_req = s_accept;
            end
            sfrp_pkg::ST_CALC: begin
                load_desc = !drop_req;
            end
            sfrp_pkg::ST_SEND: begin
                m_tvalid = 1'b1;
            end
            default: ;
        endcase
    end

    assign m_tdata = tdata_reg;
    assign m_tlast = tlast_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= sfrp_pkg::ST_IDLE;
            read_op_reg    <= sfrp_pkg::RST_READ_OP;
            program_op_reg <= sfrp_pkg::RST_PROGRAM_OP;
            sector_op_reg  <= sfrp_pkg::RST_SECTOR_OP;
            param_op_reg   <= sfrp_pkg::RST_PARAM_OP;
            chip_op_reg    <= sfrp_pkg::RST_CHIP_OP;
            param_end_reg  <= sfrp_pkg::RST_PARAM_END;
        end else begin
            state_reg <= state_next;
            if (cfg_accept) begin
                case (cfg_index)
                    sfrp_pkg::REG_READ_OP:    read_op_reg    <= cfg_data[7:0];
                    sfrp_pkg::REG_PROGRAM_OP: program_op_reg <= cfg_data[7:0];
                    sfrp_pkg::REG_SECTOR_OP:  sector_op_reg  <= cfg_data[7:0];
                    sfrp_pkg::REG_PARAM_OP:   param_op_reg   <= cfg_data[7:0];
                    sfrp_pkg::REG_CHIP_OP:    chip_op_reg    <= cfg_data[7:0];
                    sfrp_pkg::REG_PARAM_END:  param_end_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_req) begin
            cmd_reg  <= s_tuser;
            addr_reg <= s_tdata[23:0];
            left_reg <= len_clamped;
        end else if (load_desc) begin
            addr_reg <= addr_adv;
            left_reg <= left_after;
        end
        if (load_desc) begin
            tdata_reg <= {5'd0, desc.poll_after, desc.enable_first, desc.direction,
                          desc.byte_count, desc.has_address, desc.flash_address,
                          desc.opcode};
            tlast_reg <= desc.last;
        end
    end

endmodule

FILE: src/sfrp_checker.sv
`include "spi_flash_request_planner_defines.svh"

module sfrp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [sfrp_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [sfrp_pkg::CMD_W-1:0]     s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sfrp_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [sfrp_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [sfrp_pkg::END_W-1:0]     cfg_data
);

    logic [sfrp_pkg::DIR_W-1:0] m_dir;
    logic                       m_wren, m_poll;

    assign m_dir  = m_tdata[sfrp_pkg::DIR_LSB +: sfrp_pkg::DIR_W];
    assign m_wren = m_tdata[sfrp_pkg::WREN_LSB];
    assign m_poll = m_tdata[sfrp_pkg::POLL_LSB];

    `SFRP_ASSERT(a_m_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled descriptor changed")
    `SFRP_ASSERT(a_one_request, m_tvalid |-> !s_tready, "request taken while descriptors pending")
    `SFRP_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "ready right after a request transfer")
    `SFRP_ASSERT(a_dir_code, m_tvalid |-> m_dir != 2'd3, "undefined direction code")
    `SFRP_ASSERT(a_program_flags, m_tvalid && m_dir == sfrp_pkg::DIR_TX |-> m_wren && m_poll, "page program without enable or poll")

    logic unused_ok;
    assign unused_ok = ^{s_tdata, s_tuser, cfg_valid, cfg_ready, cfg_index, cfg_data};

endmodule

bind spi_flash_request_planner sfrp_checker u_sfrp_checker (.*);
